### src/int_to_ascii_radix_unit_assert.svh
// Assertion macros for the integer to text unit.
`ifndef INT_TO_ASCII_RADIX_UNIT_ASSERT_SVH
`define INT_TO_ASCII_RADIX_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication under clk, disabled in reset.
`define ITOA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itoa assertion failed");

// Next-cycle implication under clk, disabled in reset.
`define ITOA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itoa assertion failed");

`else

`define ITOA_ASSERT_IMP(lbl, ante, cons)
`define ITOA_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### src/itoa_pkg.sv
// Shared constants, types and the digit table of the integer to text unit.
package itoa_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int RADIX_BITS  = 5;
    localparam int BASE_BITS   = 5;
    localparam int DIGIT_BITS  = 4;
    localparam int CHAR_BITS   = 8;

    // Long division: bit steps per cycle and division cycles per digit.
    localparam int STEP_BITS   = 8;
    localparam int DIV_CYCLES  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int DIV_BITS    = DIV_CYCLES * STEP_BITS;
    localparam int STEP_CNT_W  = $clog2(DIV_CYCLES + 1);
    localparam int NDIG_W      = $clog2(VALUE_BITS + 1);

    // Queue between front and back; depth is a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(10);
    localparam logic [BASE_BITS-1:0]  BASE_MIN    = BASE_BITS'(2);
    localparam logic [BASE_BITS-1:0]  BASE_MAX    = BASE_BITS'(16);

    localparam logic [CHAR_BITS-1:0] MINUS_CHAR = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_BITS-1:0] CHAR_LOW_A = 8'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_LOW_F = 8'h66;

    localparam logic [CHAR_BITS-1:0] DIGIT_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    // One classified number waiting for conversion.
    typedef struct packed {
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
        logic [BASE_BITS-1:0]  base;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

### src/int_to_ascii_radix_unit.sv
// Top level of the signed integer to ASCII text converter, base 2 to 16.
//
//  channel   signals                              handshake
//  -------   -----------------------------------  ------------------------------
//  config    cfg_data[4:0]                        cfg_valid && cfg_ready
//  input     value[31:0]                          start && !busy
//  result    character[7:0], final_char           strobe, one cycle, no stall
//
//  The back end pops one number at a time, finds each digit with the 8-bit-per-cycle
//  long divider and a check step, then sends the minus sign, if any, and the digits
//  from the most significant one, and only then pops the next number from the queue.
//  The front end takes a new number whenever the two-entry queue has room; busy
//  is high only while the queue is full. Characters of one number leave in
//  consecutive cycles. Reset sets the radix to ten and empties the queue.
`include "int_to_ascii_radix_unit_assert.svh"

module int_to_ascii_radix_unit
    import itoa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [RADIX_BITS-1:0] cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  strobe,
    output logic [CHAR_BITS-1:0]  character,
    output logic                  final_char
);

    item_t         push_item;
    item_t         pop_item;
    queue_status_t q_status;
    logic          push;
    logic          pop;

    assign busy = q_status.full;

    itoa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .start      (start),
        .value      (value),
        .queue_full (q_status.full),
        .push       (push),
        .push_item  (push_item)
    );

    itoa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    itoa_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (pop_item),
        .queue_empty (q_status.empty),
        .pop         (pop),
        .strobe      (strobe),
        .character   (character),
        .final_char  (final_char)
    );

    // A number's characters leave back to back until the final one.
    `ITOA_ASSERT_NXT(a_chars_contiguous, strobe && !final_char, strobe)

    // A minus sign never ends a number.
    `ITOA_ASSERT_IMP(a_minus_not_final, strobe && (character == MINUS_CHAR), !final_char)

    // Every character is a minus, a decimal digit or a lower-case hex letter.
    `ITOA_ASSERT_IMP(a_char_legal, strobe, (character == MINUS_CHAR) || ((character >= CHAR_ZERO) && (character <= CHAR_NINE)) || ((character >= CHAR_LOW_A) && (character <= CHAR_LOW_F)))

endmodule

### src/itoa_front.sv
// Front end: radix register, input accept and sign/magnitude classification.
module itoa_front
    import itoa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [RADIX_BITS-1:0] cfg_data,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  queue_full,
    output logic                  push,
    output item_t                 push_item
);

    logic [RADIX_BITS-1:0] radix_reg;
    logic [BASE_BITS-1:0]  base;
    logic                  neg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            radix_reg <= cfg_data;
        end
    end

    // Saturate the base into the supported range.
    always_comb
    begin
        if (BASE_BITS'(radix_reg) < BASE_MIN)
        begin
            base = BASE_MIN;
        end
        else if (BASE_BITS'(radix_reg) > BASE_MAX)
        begin
            base = BASE_MAX;
        end
        else
        begin
            base = BASE_BITS'(radix_reg);
        end
    end

    assign neg  = value[VALUE_BITS-1];
    assign push = start && !queue_full;

    // Two's complement negate wraps the most negative value onto its magnitude.
    assign push_item.neg  = neg;
    assign push_item.mag  = neg ? (~value + VALUE_BITS'(1)) : value;
    assign push_item.base = base;

endmodule

### src/itoa_queue.sv
// Short queue of classified numbers between front and back.
module itoa_queue
    import itoa_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  item_t         push_item,
    input  logic          pop,
    output item_t         pop_item,
    output queue_status_t status
);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_item     = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### src/itoa_back.sv
// Back end: digit extraction by long division, digit stack and character output.
module itoa_back
    import itoa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  item_t                item,
    input  logic                 queue_empty,
    output logic                 pop,
    output logic                 strobe,
    output logic [CHAR_BITS-1:0] character,
    output logic                 final_char
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_CHECK,
        ST_MINUS,
        ST_DIGITS
    } state_t;

    state_t                 state_reg, state_next;
    logic [STEP_CNT_W-1:0]  step_reg, step_next;
    logic [NDIG_W-1:0]      ndig_reg, ndig_next;
    logic                   neg_reg, neg_next;
    logic [BASE_BITS-1:0]   base_reg, base_next;
    logic                   strobe_reg, strobe_next;
    logic [CHAR_BITS-1:0]   char_reg, char_next;
    logic                   final_reg, final_next;

    logic [DIV_BITS-1:0]    div_reg, div_next;
    logic [DIGIT_BITS-1:0]  rem_reg, rem_next;
    logic [DIGIT_BITS-1:0]  stack_reg [VALUE_BITS];

    logic [DIV_BITS-1:0]    div_step;
    logic [DIGIT_BITS-1:0]  rem_step;
    logic                   stack_push;
    logic                   stack_pop;
    logic                   conv_done;

    // Several restoring division steps per cycle; divisor is at most five bits.
    always_comb
    begin
        logic [DIV_BITS-1:0]   d;
        logic [DIGIT_BITS-1:0] r;
        logic [BASE_BITS-1:0]  t;
        d = div_reg;
        r = rem_reg;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            t = {r, d[DIV_BITS-1]};
            d = {d[DIV_BITS-2:0], 1'b0};
            if (t >= base_reg)
            begin
                t    = t - base_reg;
                d[0] = 1'b1;
            end
            r = t[DIGIT_BITS-1:0];
        end
        div_step = d;
        rem_step = r;
    end

    assign conv_done = (div_reg == '0) || (ndig_reg == NDIG_W'(VALUE_BITS));

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        ndig_next   = ndig_reg;
        neg_next    = neg_reg;
        base_next   = base_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        final_next  = final_reg;
        div_next    = div_reg;
        rem_next    = rem_reg;
        stack_push  = 1'b0;
        stack_pop   = 1'b0;
        pop         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    neg_next   = item.neg;
                    base_next  = item.base;
                    div_next   = DIV_BITS'(item.mag);
                    rem_next   = '0;
                    ndig_next  = '0;
                    step_next  = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                div_next  = div_step;
                rem_next  = rem_step;
                step_next = step_reg + STEP_CNT_W'(1);
                if (step_reg == STEP_CNT_W'(DIV_CYCLES - 1))
                begin
                    stack_push = 1'b1;
                    ndig_next  = ndig_reg + NDIG_W'(1);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                step_next = '0;
                rem_next  = '0;
                if (conv_done)
                begin
                    state_next = neg_reg ? ST_MINUS : ST_DIGITS;
                end
                else
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_MINUS:
            begin
                strobe_next = 1'b1;
                char_next   = MINUS_CHAR;
                final_next  = 1'b0;
                state_next  = ST_DIGITS;
            end
            ST_DIGITS:
            begin
                strobe_next = 1'b1;
                char_next   = DIGIT_CHARS[stack_reg[0]];
                final_next  = (ndig_reg == NDIG_W'(1));
                stack_pop   = 1'b1;
                ndig_next   = ndig_reg - NDIG_W'(1);
                if (ndig_reg == NDIG_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            ndig_reg   <= '0;
            strobe_reg <= 1'b0;
            char_reg   <= '0;
            final_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            ndig_reg   <= ndig_next;
            strobe_reg <= strobe_next;
            char_reg   <= char_next;
            final_reg  <= final_next;
        end
    end

    // Working registers: dividend/quotient, remainder, item fields, digit stack.
    always_ff @(posedge clk)
    begin
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        base_reg <= base_next;
        // Push least significant digit first, pop from the top for msd-first output.
        if (stack_push)
        begin
            stack_reg[0] <= rem_step;
            for (int i = 1; i < VALUE_BITS; i++)
            begin
                stack_reg[i] <= stack_reg[i-1];
            end
        end
        else if (stack_pop)
        begin
            for (int i = 0; i < VALUE_BITS - 1; i++)
            begin
                stack_reg[i] <= stack_reg[i+1];
            end
        end
    end

    assign strobe     = strobe_reg;
    assign character  = char_reg;
    assign final_char = final_reg;

endmodule
